### rtl/scba_pkg.sv
// Shared types, constants and helper functions of the size-class block pool allocator.
package scba_pkg;

    // Class sizes in blocks or slots
    localparam int BIG_BLOCKS    = 16;
    localparam int MEDIUM_BLOCKS = 32;
    localparam int SMALL_BLOCKS  = 64;
    localparam int TINY_BLOCKS   = 64;
    localparam int SINGLE_SLOTS  = 64;
    localparam int DOUBLE_SLOTS  = 64;

    localparam int CLASS_COUNT = 6;
    localparam int CLASS_W     = 3;
    localparam int STORE_DEPTH = BIG_BLOCKS + MEDIUM_BLOCKS + SMALL_BLOCKS + TINY_BLOCKS
                                 + DOUBLE_SLOTS + SINGLE_SLOTS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    localparam int INDEX_W = 6;
    localparam int COUNT_W = 7;
    localparam int BYTES_W = 16;
    localparam int CNT_W   = 32;
    localparam int LEAK_W  = 33;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Reset values of the size registers
    localparam logic [BYTES_W-1:0] BIG_BYTES_RST    = 16'd512;
    localparam logic [BYTES_W-1:0] MEDIUM_BYTES_RST = 16'd256;
    localparam logic [BYTES_W-1:0] SMALL_BYTES_RST  = 16'd64;
    localparam logic [BYTES_W-1:0] TINY_BYTES_RST   = 16'd16;

    // Fixed sizes of the slot classes
    localparam logic [BYTES_W-1:0] DOUBLE_BYTES = 16'd2;
    localparam logic [BYTES_W-1:0] SINGLE_BYTES = 16'd1;

    typedef enum logic [1:0] {
        REG_BIG    = 2'd0,
        REG_MEDIUM = 2'd1,
        REG_SMALL  = 2'd2,
        REG_TINY   = 2'd3
    } scba_reg_idx_t;

    // Classes in match order
    typedef enum logic [CLASS_W-1:0] {
        CL_BIG    = 3'd0,
        CL_MEDIUM = 3'd1,
        CL_SMALL  = 3'd2,
        CL_TINY   = 3'd3,
        CL_DOUBLE = 3'd4,
        CL_SINGLE = 3'd5,
        CL_NONE   = 3'd6
    } scba_class_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } scba_cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_UNKNOWN = 2'd3
    } scba_status_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_READ = 1'b1
    } scba_back_state_t;

    typedef struct packed {
        logic [BYTES_W-1:0] big_bytes;
        logic [BYTES_W-1:0] medium_bytes;
        logic [BYTES_W-1:0] small_bytes;
        logic [BYTES_W-1:0] tiny_bytes;
    } scba_cfg_t;

    // One classified request between front and back
    typedef struct packed {
        scba_cmd_t          cmd;
        scba_class_t        cls;
        logic [INDEX_W-1:0] free_index;
    } scba_item_t;

    function automatic logic [COUNT_W-1:0] class_size(input scba_class_t c);
        logic [COUNT_W-1:0] s;
        unique case (c)
            CL_BIG:    s = COUNT_W'(BIG_BLOCKS);
            CL_MEDIUM: s = COUNT_W'(MEDIUM_BLOCKS);
            CL_SMALL:  s = COUNT_W'(SMALL_BLOCKS);
            CL_TINY:   s = COUNT_W'(TINY_BLOCKS);
            CL_DOUBLE: s = COUNT_W'(DOUBLE_SLOTS);
            CL_SINGLE: s = COUNT_W'(SINGLE_SLOTS);
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [STORE_AW-1:0] class_base(input scba_class_t c);
        logic [STORE_AW-1:0] b;
        unique case (c)
            CL_BIG:    b = '0;
            CL_MEDIUM: b = STORE_AW'(BIG_BLOCKS);
            CL_SMALL:  b = STORE_AW'(BIG_BLOCKS + MEDIUM_BLOCKS);
            CL_TINY:   b = STORE_AW'(BIG_BLOCKS + MEDIUM_BLOCKS + SMALL_BLOCKS);
            CL_DOUBLE: b = STORE_AW'(BIG_BLOCKS + MEDIUM_BLOCKS + SMALL_BLOCKS
                                     + TINY_BLOCKS);
            CL_SINGLE: b = STORE_AW'(BIG_BLOCKS + MEDIUM_BLOCKS + SMALL_BLOCKS
                                     + TINY_BLOCKS + DOUBLE_SLOTS);
            default:   b = '0;
        endcase
        return b;
    endfunction

    // Advance a ring position, wrapping at the class size
    function automatic logic [INDEX_W-1:0] ring_next(input scba_class_t c,
                                                     input logic [INDEX_W-1:0] p);
        logic [COUNT_W-1:0] inc;
        inc = {1'b0, p} + COUNT_W'(1);
        return (inc >= class_size(c)) ? '0 : inc[INDEX_W-1:0];
    endfunction

endpackage

### rtl/size_class_block_pool_allocator_core.sv
// Top level of the size-class block pool allocator: register port, front and back parts.
//
// Six classes (big, medium, small, tiny, double-byte, single-byte) each keep a FIFO ring of
// free block indices, full with 0..N-1 after reset; no clearing pass is needed, since ring
// entries not yet written since reset read as their own position. A request is classified
// on entry and waits in a two-entry queue. The back part does a free or unknown size in
// idle; an allocate also waits in a read state for the registered free-index RAM read.
// Results sit in an output register; the next item issues once it is empty or taken. The
// user must write size registers through the register port only while idle; unenforced.
module size_class_block_pool_allocator_core
    import scba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    // Request channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [BYTES_W-1:0] request_bytes,
    input  logic [INDEX_W-1:0] free_index,
    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] granted_index,
    output logic [1:0]         status,
    output logic [LEAK_W-1:0]  leak_count
);

    scba_cfg_t     cfg_reg, cfg_next;
    scba_reg_idx_t reg_idx;
    logic          wr_en;
    logic [BYTES_W-1:0] rd_val;
    logic          q_valid;
    scba_item_t    q_item;
    logic          q_pop;

    assign pready  = 1'b1;
    assign reg_idx = scba_reg_idx_t'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Decode register writes and reads
    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (reg_idx)
            REG_BIG:    rd_val = cfg_reg.big_bytes;
            REG_MEDIUM: rd_val = cfg_reg.medium_bytes;
            REG_SMALL:  rd_val = cfg_reg.small_bytes;
            REG_TINY:   rd_val = cfg_reg.tiny_bytes;
            default:    rd_val = '0;
        endcase
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BIG:    cfg_next.big_bytes    = pwdata[BYTES_W-1:0];
                REG_MEDIUM: cfg_next.medium_bytes = pwdata[BYTES_W-1:0];
                REG_SMALL:  cfg_next.small_bytes  = pwdata[BYTES_W-1:0];
                REG_TINY:   cfg_next.tiny_bytes   = pwdata[BYTES_W-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    assign prdata = {{(APB_DW-BYTES_W){1'b0}}, rd_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.big_bytes    <= BIG_BYTES_RST;
            cfg_reg.medium_bytes <= MEDIUM_BYTES_RST;
            cfg_reg.small_bytes  <= SMALL_BYTES_RST;
            cfg_reg.tiny_bytes   <= TINY_BYTES_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    scba_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .request_bytes (request_bytes),
        .free_index    (free_index),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    scba_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted_index (granted_index),
        .status        (status),
        .leak_count    (leak_count)
    );

endmodule

### rtl/scba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module scba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/scba_front.sv
// Front part: classifies incoming requests by size and queues them for the back part.
module scba_front
    import scba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  scba_cfg_t          cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [BYTES_W-1:0] request_bytes,
    input  logic [INDEX_W-1:0] free_index,
    output logic               q_valid,
    output scba_item_t         q_item,
    input  logic               q_pop
);

    scba_item_t  q_mem_reg [2];
    logic        q_wr_ptr_reg, q_wr_ptr_next;
    logic        q_rd_ptr_reg, q_rd_ptr_next;
    logic [1:0]  q_count_reg, q_count_next;
    logic        in_take;
    scba_class_t cls;
    scba_item_t  new_item;

    // Pick the class by exact size match, first match wins
    always_comb
    begin
        priority if (request_bytes == cfg.big_bytes)    cls = CL_BIG;
        else if (request_bytes == cfg.medium_bytes)     cls = CL_MEDIUM;
        else if (request_bytes == cfg.small_bytes)      cls = CL_SMALL;
        else if (request_bytes == cfg.tiny_bytes)       cls = CL_TINY;
        else if (request_bytes == DOUBLE_BYTES)         cls = CL_DOUBLE;
        else if (request_bytes == SINGLE_BYTES)         cls = CL_SINGLE;
        else                                            cls = CL_NONE;
    end

    assign new_item = '{cmd: scba_cmd_t'(cmd), cls: cls, free_index: free_index};

    assign in_stall = (q_count_reg == 2'd2);
    assign in_take  = in_valid && !in_stall;
    assign q_valid  = (q_count_reg != 2'd0);
    assign q_item   = q_mem_reg[q_rd_ptr_reg];

    // Advance queue pointers and count
    always_comb
    begin
        q_wr_ptr_next = q_wr_ptr_reg ^ in_take;
        q_rd_ptr_next = q_rd_ptr_reg ^ q_pop;
        q_count_next  = q_count_reg + {1'b0, in_take} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
            q_count_reg  <= 2'd0;
        end
        else
        begin
            q_wr_ptr_reg <= q_wr_ptr_next;
            q_rd_ptr_reg <= q_rd_ptr_next;
            q_count_reg  <= q_count_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            q_mem_reg[q_wr_ptr_reg] <= new_item;
        end
    end

endmodule

### rtl/scba_back.sv
// Back part: runs allocate and free on the per-class free rings and holds the result.
module scba_back
    import scba_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  scba_item_t         q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [INDEX_W-1:0] granted_index,
    output logic [1:0]         status,
    output logic [LEAK_W-1:0]  leak_count
);

    scba_back_state_t   state_reg, state_next;

    logic [INDEX_W-1:0] rp_reg   [CLASS_COUNT];
    logic [INDEX_W-1:0] rp_next  [CLASS_COUNT];
    logic [INDEX_W-1:0] wp_reg   [CLASS_COUNT];
    logic [INDEX_W-1:0] wp_next  [CLASS_COUNT];
    logic [COUNT_W-1:0] fill_reg [CLASS_COUNT];
    logic [COUNT_W-1:0] fill_next[CLASS_COUNT];
    // Entries below this mark in a ring have been written since reset
    logic [COUNT_W-1:0] mark_reg [CLASS_COUNT];
    logic [COUNT_W-1:0] mark_next[CLASS_COUNT];

    logic [CNT_W-1:0]   small_cnt_reg, small_cnt_next;
    logic [CNT_W-1:0]   tiny_cnt_reg, tiny_cnt_next;

    logic               pend_hit_reg, pend_hit_next;
    logic [INDEX_W-1:0] pend_pos_reg, pend_pos_next;
    logic [CLASS_W-1:0] pend_cls_reg, pend_cls_next;

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] granted_reg, granted_next;
    scba_status_t       status_reg, status_next;
    logic [LEAK_W-1:0]  leak_reg, leak_next;

    logic               out_take;
    logic               issue;
    logic [CLASS_W-1:0] ci;
    logic [LEAK_W-1:0]  leak_sum;
    logic               ram_we, ram_re;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [INDEX_W-1:0] ram_rdata;

    assign out_take = out_valid_reg && !out_stall;
    assign issue    = (state_reg == BK_IDLE) && q_valid && (!out_valid_reg || out_take);
    assign q_pop    = issue;
    assign ci       = q_item.cls;
    assign leak_sum = {1'b0, small_cnt_reg} + {1'b0, tiny_cnt_reg};

    // Sequence each item and update rings, counters and result
    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        mark_next      = mark_reg;
        small_cnt_next = small_cnt_reg;
        tiny_cnt_next  = tiny_cnt_reg;
        pend_hit_next  = pend_hit_reg;
        pend_pos_next  = pend_pos_reg;
        pend_cls_next  = pend_cls_reg;
        out_valid_next = out_valid_reg && !out_take;
        granted_next   = granted_reg;
        status_next    = status_reg;
        leak_next      = leak_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = class_base(q_item.cls) + STORE_AW'(wp_reg[ci]);
        ram_raddr      = class_base(q_item.cls) + STORE_AW'(rp_reg[ci]);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (issue)
                begin
                    priority if (q_item.cls == CL_NONE)
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = '0;
                        status_next    = ST_UNKNOWN;
                        leak_next      = leak_sum;
                    end
                    else if (q_item.cmd == CMD_FREE)
                    begin
                        out_valid_next = 1'b1;
                        granted_next   = '0;
                        leak_next      = leak_sum;
                        if (fill_reg[ci] >= class_size(q_item.cls))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we        = 1'b1;
                            wp_next[ci]   = ring_next(q_item.cls, wp_reg[ci]);
                            fill_next[ci] = fill_reg[ci] + COUNT_W'(1);
                            if (mark_reg[ci] < class_size(q_item.cls))
                            begin
                                mark_next[ci] = mark_reg[ci] + COUNT_W'(1);
                            end
                            status_next = ST_OK;
                        end
                    end
                    else
                    begin
                        // Count small and tiny attempts, failed ones too
                        if (q_item.cls == CL_SMALL)
                        begin
                            small_cnt_next = small_cnt_reg + CNT_W'(1);
                        end
                        if (q_item.cls == CL_TINY)
                        begin
                            tiny_cnt_next = tiny_cnt_reg + CNT_W'(1);
                        end
                        pend_cls_next = ci;
                        pend_pos_next = rp_reg[ci];
                        if (fill_reg[ci] == '0)
                        begin
                            pend_hit_next = 1'b0;
                        end
                        else
                        begin
                            pend_hit_next = 1'b1;
                            ram_re        = 1'b1;
                            rp_next[ci]   = ring_next(q_item.cls, rp_reg[ci]);
                            fill_next[ci] = fill_reg[ci] - COUNT_W'(1);
                        end
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                // Unwritten entries read as their ring position in place of the RAM data
                out_valid_next = 1'b1;
                leak_next      = leak_sum;
                if (pend_hit_reg)
                begin
                    status_next  = ST_OK;
                    granted_next = ({1'b0, pend_pos_reg} < mark_reg[pend_cls_reg])
                                   ? ram_rdata : pend_pos_reg;
                end
                else
                begin
                    status_next  = ST_EMPTY;
                    granted_next = '0;
                end
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            small_cnt_reg <= '0;
            tiny_cnt_reg  <= '0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                rp_reg[i]   <= '0;
                wp_reg[i]   <= '0;
                fill_reg[i] <= class_size(scba_class_t'(i));
                mark_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            small_cnt_reg <= small_cnt_next;
            tiny_cnt_reg  <= tiny_cnt_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            mark_reg      <= mark_next;
        end
    end

    // Hold pending item and result payload
    always_ff @(posedge clk)
    begin
        pend_hit_reg <= pend_hit_next;
        pend_pos_reg <= pend_pos_next;
        pend_cls_reg <= pend_cls_next;
        granted_reg  <= granted_next;
        status_reg   <= status_next;
        leak_reg     <= leak_next;
    end

    scba_ram #(
        .WIDTH (INDEX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.free_index),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign leak_count    = leak_reg;

    // The result register is free when read data comes back
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |-> !out_valid_reg)
    else $error("result register occupied during store read");

    // The read state is always followed by idle with a valid result
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == BK_READ |=> state_reg == BK_IDLE && out_valid_reg)
    else $error("allocate read did not complete");

    // Store read and write never happen together
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
    else $error("store read and write in same cycle");

    // A store read always follows a class that had free entries
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> pend_hit_reg && state_reg == BK_READ)
    else $error("store read without pending grant");

endmodule
